// ===== src/swfm_pkg.sv =====
// Shared types and constants of the sensor warning/fatal monitor.
package swfm_pkg;

  localparam int VAL_W = 32;
  localparam int IDX_FIELD_W = 7;

  // Item operations.
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Threshold kinds, also the bit of each kind in the valid mask.
  localparam logic [1:0] KIND_HIGH_FATAL = 2'd0;
  localparam logic [1:0] KIND_HIGH_WARN  = 2'd1;
  localparam logic [1:0] KIND_LOW_FATAL  = 2'd2;
  localparam logic [1:0] KIND_LOW_WARN   = 2'd3;

  // Result levels.
  localparam logic [1:0] LVL_NORMAL = 2'd0;
  localparam logic [1:0] LVL_WARN   = 2'd1;
  localparam logic [1:0] LVL_FATAL  = 2'd2;
  localparam logic [1:0] LVL_SKIP   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ERROR_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_TEMP_MARGIN   = 2'd1;
  localparam logic [1:0] CFG_POWER_PERCENT = 2'd2;

  localparam logic [4:0] ERROR_LIMIT_RST   = 5'd25;
  localparam logic [9:0] TEMP_MARGIN_RST   = 10'd5;
  localparam logic [5:0] POWER_PERCENT_RST = 6'd5;
  localparam logic [4:0] ERROR_COUNT_MAX   = 5'd31;

  typedef struct packed {
    logic [1:0]             operation;
    logic [IDX_FIELD_W-1:0] sensor_index;
    logic                   read_ok;
    logic [VAL_W-1:0]       sample_value;
    logic [1:0]             threshold_kind;
    logic                   threshold_present;
    logic                   temp_sensor;
    logic                   last_in_scan;
  } swfm_in_t;

  typedef struct packed {
    logic [1:0]       level;
    logic             raise_event;
    logic             newly_tripped;
    logic             still_tripped;
    logic             back_to_normal;
    logic             now_ignored;
    logic             scan_fatal;
    logic             all_clear;
    logic [VAL_W-1:0] stored_threshold;
  } swfm_out_t;

endpackage

// ===== src/swfm_margin.sv =====
// Three-stage pipeline computing floor(value * percent / 100).
module swfm_margin (
  input  logic                       clk,
  input  logic                       adv,
  input  logic [swfm_pkg::VAL_W-1:0] value,
  input  logic [5:0]                 pct,
  output logic [swfm_pkg::VAL_W-1:0] margin
);

  // value / 100 is exact as (value * RECIP_100) >> 38 for every 32-bit value.
  localparam logic [31:0] RECIP_100 = 32'd2748779070;
  localparam logic [12:0] RECIP_SMALL = 13'd5243;
  localparam logic [6:0]  HUNDRED = 7'd100;

  logic [63:0] prod;
  logic [25:0] quot_r;
  logic [31:0] val1_r;
  logic [5:0]  pct1_r;
  logic [31:0] quot100;
  logic [6:0]  rem;
  logic [31:0] qp_r;
  logic [12:0] rp_r;
  logic [25:0] small_prod;
  logic [31:0] margin_r;

  assign prod = 64'(value) * 64'(RECIP_100);

  assign quot100 = 32'(quot_r) * 32'(HUNDRED);
  assign rem     = 7'(val1_r - quot100);

  assign small_prod = 26'(rp_r) * 26'(RECIP_SMALL);

  always_ff @(posedge clk) begin
    if (adv) begin
      quot_r   <= prod[63:38];
      val1_r   <= value;
      pct1_r   <= pct;
      qp_r     <= 32'(quot_r) * 32'(pct1_r);
      rp_r     <= 13'(rem) * 13'(pct1_r);
      // The percentage is at most 63, so the sum stays below 2^32.
      margin_r <= 32'(qp_r + 32'(small_prod[25:19]));
    end
  end

  assign margin = margin_r;

endmodule

// ===== src/sensor_warn_fatal_monitor.sv =====
// Top level of the per-sensor warning/fatal threshold monitor.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------
//   in      | input     | in_valid/in_stall  | in_data (swfm_in_t)
//   out     | output    | out_valid/out_stall| out_data (swfm_out_t)
//   cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One transaction per cycle while in_stall is low; an accepted transaction moves
// through stages s1, s2 and s3, and its result is then registered onto out_data.
// The per-sensor state is read in stage s2 and registered for the write-back stage, and a
// one-entry bypass covers a transaction on the same sensor right behind.
// After reset a clearing pass writes SENSORS status entries, one per cycle,
// while in_stall is held high; configuration writes are taken throughout.
// A stalled output freezes the whole pipeline and raises in_stall.
module sensor_warn_fatal_monitor #(
  parameter int SENSORS = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  swfm_pkg::swfm_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output swfm_pkg::swfm_out_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data
);

  localparam int IDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(SENSORS - 1);
  localparam int SCAN_FATAL  = 0;
  localparam int SCAN_RETURN = 1;
  localparam int SCAN_TRIP   = 2;

  typedef struct packed {
    logic [3:0] valid;
    logic [4:0] err_cnt;
    logic       ignore;
    logic       prev_trip;
  } stat_t;

  // Configuration registers.
  logic [4:0] err_limit_r;
  logic [9:0] temp_margin_r;
  logic [5:0] pct_r;

  // Pipeline.
  logic                adv;
  logic                accept;
  logic                s1_v_r, s2_v_r, s3_v_r;
  swfm_pkg::swfm_in_t  s1_item_r, s2_item_r, s3_item_r;
  logic [swfm_pkg::VAL_W-1:0] pct_margin;

  // Memories and their ports.
  logic [3:0][swfm_pkg::VAL_W-1:0] thr_mem [SENSORS];
  stat_t                           stat_mem [SENSORS];
  logic [3:0][swfm_pkg::VAL_W-1:0] thr_rd_r;
  stat_t                           stat_rd_r;
  logic [IDX_W-1:0]                rd_addr;
  logic [IDX_W-1:0]                s3_addr;
  logic [IDX_W-1:0]                stat_wr_addr;
  stat_t                           stat_wr_data;
  logic                            stat_we;
  logic                            pipe_stat_we;
  logic                            thr_we;

  // Bypass of the last write-back.
  logic                       fwd_v_r;
  logic                       fwd_thr_we_r;
  logic [IDX_W-1:0]           fwd_addr_r;
  logic [1:0]                 fwd_kind_r;
  stat_t                      fwd_stat_r;
  logic [swfm_pkg::VAL_W-1:0] fwd_thr_r;

  // Clearing pass.
  logic             clr_busy_r;
  logic [IDX_W-1:0] clr_ptr_r;

  // Write-back stage.
  logic                            in_range;
  logic                            fwd_hit;
  stat_t                           cur_stat;
  stat_t                           new_stat;
  logic [3:0][swfm_pkg::VAL_W-1:0] thr;
  logic [swfm_pkg::VAL_W-1:0]      margin;
  logic [swfm_pkg::VAL_W:0]        sum;
  logic [swfm_pkg::VAL_W-1:0]      adj;
  logic [swfm_pkg::VAL_W-1:0]      val;
  logic [4:0]                      err_nxt;
  logic                            fatal, warn, normal, tripped;
  logic [2:0]                      scan_flags_r, scan_flags_nxt;
  swfm_pkg::swfm_out_t             res;

  logic                out_valid_r;
  swfm_pkg::swfm_out_t out_data_r;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = clr_busy_r || !adv;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_limit_r   <= swfm_pkg::ERROR_LIMIT_RST;
      temp_margin_r <= swfm_pkg::TEMP_MARGIN_RST;
      pct_r         <= swfm_pkg::POWER_PERCENT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        swfm_pkg::CFG_ERROR_LIMIT:   err_limit_r   <= cfg_data[4:0];
        swfm_pkg::CFG_TEMP_MARGIN:   temp_margin_r <= cfg_data;
        swfm_pkg::CFG_POWER_PERCENT: pct_r         <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  swfm_margin u_margin (
    .clk    (clk),
    .adv    (adv),
    .value  (in_data.sample_value),
    .pct    (pct_r),
    .margin (pct_margin)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= in_data;
      s2_item_r <= s1_item_r;
      s3_item_r <= s2_item_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_ptr_r  <= '0;
    end else if (clr_busy_r) begin
      clr_ptr_r <= IDX_W'(clr_ptr_r + 1'b1);
      if (clr_ptr_r == LAST_ENTRY) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign rd_addr = IDX_W'(s2_item_r.sensor_index);
  assign s3_addr = IDX_W'(s3_item_r.sensor_index);

  assign stat_we      = clr_busy_r || pipe_stat_we;
  assign stat_wr_addr = clr_busy_r ? clr_ptr_r : s3_addr;
  assign stat_wr_data = clr_busy_r ? stat_t'('0) : new_stat;

  always_ff @(posedge clk) begin
    if (thr_we) begin
      thr_mem[s3_addr][s3_item_r.threshold_kind] <= adj;
    end
    if (adv) begin
      thr_rd_r <= thr_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (stat_we) begin
      stat_mem[stat_wr_addr] <= stat_wr_data;
    end
    if (adv) begin
      stat_rd_r <= stat_mem[rd_addr];
    end
  end

  // The entry read together with the last write-back missed that write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r      <= 1'b0;
      fwd_thr_we_r <= 1'b0;
    end else if (adv) begin
      fwd_v_r      <= pipe_stat_we;
      fwd_thr_we_r <= thr_we;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_addr_r <= s3_addr;
      fwd_kind_r <= s3_item_r.threshold_kind;
      fwd_stat_r <= new_stat;
      fwd_thr_r  <= adj;
    end
  end

  assign in_range = int'(s3_item_r.sensor_index) < SENSORS;
  assign fwd_hit  = fwd_addr_r == s3_addr;
  assign cur_stat = (fwd_v_r && fwd_hit) ? fwd_stat_r : stat_rd_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      thr[k] = (fwd_thr_we_r && fwd_hit && fwd_kind_r == 2'(k)) ? fwd_thr_r : thr_rd_r[k];
    end
  end

  assign val    = s3_item_r.sample_value;
  assign margin = s3_item_r.temp_sensor ? swfm_pkg::VAL_W'(temp_margin_r) : pct_margin;
  assign sum    = {1'b0, val} + {1'b0, margin};

  always_comb begin
    if (s3_item_r.threshold_kind == swfm_pkg::KIND_HIGH_FATAL ||
        s3_item_r.threshold_kind == swfm_pkg::KIND_HIGH_WARN) begin
      adj = (margin > val) ? '0 : val - margin;
    end else begin
      adj = sum[swfm_pkg::VAL_W] ? '1 : sum[swfm_pkg::VAL_W-1:0];
    end
  end

  assign err_nxt = (cur_stat.err_cnt < swfm_pkg::ERROR_COUNT_MAX) ?
                   5'(cur_stat.err_cnt + 5'd1) : cur_stat.err_cnt;

  assign fatal = (cur_stat.valid[swfm_pkg::KIND_HIGH_FATAL] &&
                  val > thr[swfm_pkg::KIND_HIGH_FATAL]) ||
                 (cur_stat.valid[swfm_pkg::KIND_LOW_FATAL] &&
                  val < thr[swfm_pkg::KIND_LOW_FATAL]);
  assign warn = (cur_stat.valid[swfm_pkg::KIND_HIGH_WARN] &&
                 val > thr[swfm_pkg::KIND_HIGH_WARN]) ||
                (cur_stat.valid[swfm_pkg::KIND_LOW_WARN] &&
                 val < thr[swfm_pkg::KIND_LOW_WARN]);
  assign normal = (cur_stat.valid[swfm_pkg::KIND_HIGH_WARN] &&
                   val <= thr[swfm_pkg::KIND_HIGH_WARN]) ||
                  (cur_stat.valid[swfm_pkg::KIND_LOW_WARN] &&
                   val >= thr[swfm_pkg::KIND_LOW_WARN]);
  assign tripped = fatal || warn;

  always_comb begin
    new_stat       = cur_stat;
    res            = '0;
    scan_flags_nxt = scan_flags_r;
    pipe_stat_we   = 1'b0;
    thr_we         = 1'b0;
    case (s3_item_r.operation)
      swfm_pkg::OP_LOAD: begin
        if (in_range) begin
          pipe_stat_we = 1'b1;
          if (s3_item_r.threshold_present) begin
            thr_we = 1'b1;
            new_stat.valid[s3_item_r.threshold_kind] = 1'b1;
            res.stored_threshold = adj;
          end else begin
            new_stat.valid[s3_item_r.threshold_kind] = 1'b0;
          end
        end
      end
      swfm_pkg::OP_CLEAR: begin
        if (in_range) begin
          pipe_stat_we     = 1'b1;
          new_stat.valid   = '0;
          new_stat.err_cnt = '0;
          new_stat.ignore  = 1'b0;
        end
      end
      swfm_pkg::OP_SAMPLE: begin
        if (!in_range || cur_stat.ignore) begin
          res.level = swfm_pkg::LVL_SKIP;
          if (in_range) begin
            pipe_stat_we       = 1'b1;
            new_stat.prev_trip = 1'b0;
          end
        end else if (!s3_item_r.read_ok) begin
          pipe_stat_we       = 1'b1;
          res.level          = swfm_pkg::LVL_SKIP;
          new_stat.err_cnt   = err_nxt;
          new_stat.prev_trip = 1'b0;
          if (err_nxt >= err_limit_r) begin
            new_stat.ignore = 1'b1;
            res.now_ignored = 1'b1;
          end
        end else begin
          pipe_stat_we       = 1'b1;
          res.level          = fatal ? swfm_pkg::LVL_FATAL :
                               (warn ? swfm_pkg::LVL_WARN : swfm_pkg::LVL_NORMAL);
          res.raise_event    = tripped;
          res.newly_tripped  = tripped && !cur_stat.prev_trip;
          res.still_tripped  = tripped && cur_stat.prev_trip;
          res.back_to_normal = normal && cur_stat.prev_trip;
          new_stat.prev_trip = tripped;
          if (fatal) begin
            scan_flags_nxt[SCAN_FATAL] = 1'b1;
          end
          if (normal && cur_stat.prev_trip) begin
            scan_flags_nxt[SCAN_RETURN] = 1'b1;
          end
          if (tripped) begin
            scan_flags_nxt[SCAN_TRIP] = 1'b1;
          end
        end
        if (s3_item_r.last_in_scan) begin
          res.scan_fatal = scan_flags_nxt[SCAN_FATAL];
          res.all_clear  = scan_flags_nxt[SCAN_RETURN] && !scan_flags_nxt[SCAN_TRIP];
          scan_flags_nxt = '0;
        end
      end
      default: ;
    endcase
    if (!s3_v_r || !adv) begin
      pipe_stat_we = 1'b0;
      thr_we       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_flags_r <= '0;
    end else if (adv && s3_v_r) begin
      scan_flags_r <= scan_flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_v_r) begin
      out_data_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_v_r)
    else $error("accepted transaction did not enter the pipeline");

  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!s1_v_r && !s2_v_r && !s3_v_r))
    else $error("transaction in flight during the clearing pass");

  a_event_matches_trip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.raise_event ==
                     (out_data_r.newly_tripped || out_data_r.still_tripped)))
    else $error("raise_event disagrees with the trip flags");

  a_scan_summary_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.scan_fatal && out_data_r.all_clear))
    else $error("scan reported fatal and all clear together");
`endif

endmodule

// ===== sim/sensor_warn_fatal_monitor_tb.sv =====
// Self-checking testbench for the sensor warning/fatal threshold monitor.
module sensor_warn_fatal_monitor_tb;

  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int REPORT_LIMIT    = 10;
  localparam logic [6:0] S_FIRST = 7'd0;
  localparam logic [6:0] S_DIR   = 7'd1;
  localparam logic [6:0] S_LAST  = 7'd127;

  typedef enum logic [1:0] {
    STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE
  } stall_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  swfm_pkg::swfm_in_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  swfm_pkg::swfm_out_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = swfm_pkg::CFG_ERROR_LIMIT;
  logic [9:0]          cfg_data = '0;

  // Predicted per-sensor state and register copies.
  logic [31:0] thr_store [512] = '{default: '0};
  logic [3:0]  thr_valid [128] = '{default: '0};
  logic [4:0]  err_count [128] = '{default: '0};
  logic        ignored [128] = '{default: 1'b0};
  logic        was_tripped [128] = '{default: 1'b0};
  logic        seen_fatal = 1'b0;
  logic        seen_return = 1'b0;
  logic        seen_trip = 1'b0;
  logic [4:0]  cur_error_limit = swfm_pkg::ERROR_LIMIT_RST;
  logic [9:0]  cur_temp_margin = swfm_pkg::TEMP_MARGIN_RST;
  logic [5:0]  cur_power_pct = swfm_pkg::POWER_PERCENT_RST;

  swfm_pkg::swfm_out_t pending_reports [$];

  int n_items_sent = 0;
  int n_results = 0;
  int n_fatal = 0;
  int n_warn = 0;
  int n_skip = 0;
  int n_newly_ignored = 0;
  int n_settings = 0;
  int mismatches = 0;
  int burst_left = 1;
  int read_fail_pct = 10;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int mode_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  sensor_warn_fatal_monitor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Works out the report of one transaction and advances the predicted state.
  function automatic swfm_pkg::swfm_out_t monitor_step(input swfm_pkg::swfm_in_t it);
    swfm_pkg::swfm_out_t r;
    logic [6:0] s;
    logic [1:0] k;
    logic [31:0] v;
    logic [63:0] m;
    logic [63:0] adj;
    logic [3:0] vb;
    logic fatal, warn, calm, trip, prev;
    r = '0;
    s = it.sensor_index;
    k = it.threshold_kind;
    v = it.sample_value;
    case (it.operation)
      swfm_pkg::OP_LOAD: begin
        if (it.threshold_present) begin
          if (it.temp_sensor) m = 64'(cur_temp_margin);
          else m = (64'(v) * 64'(cur_power_pct)) / 64'd100;
          // High thresholds move down, low thresholds move up.
          if (!k[1]) adj = (m > 64'(v)) ? 64'd0 : 64'(v) - m;
          else adj = (64'(v) + m > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : 64'(v) + m;
          thr_store[{s, k}] = adj[31:0];
          thr_valid[s][k] = 1'b1;
          r.stored_threshold = adj[31:0];
        end else begin
          thr_valid[s][k] = 1'b0;
        end
      end
      swfm_pkg::OP_CLEAR: begin
        thr_valid[s] = '0;
        err_count[s] = '0;
        ignored[s] = 1'b0;
      end
      swfm_pkg::OP_SAMPLE: begin
        if (ignored[s]) begin
          r.level = swfm_pkg::LVL_SKIP;
          was_tripped[s] = 1'b0;
        end else if (!it.read_ok) begin
          r.level = swfm_pkg::LVL_SKIP;
          if (err_count[s] != swfm_pkg::ERROR_COUNT_MAX)
            err_count[s] = err_count[s] + 5'd1;
          if (err_count[s] >= cur_error_limit) begin
            ignored[s] = 1'b1;
            r.now_ignored = 1'b1;
          end
          was_tripped[s] = 1'b0;
        end else begin
          vb = thr_valid[s];
          fatal = (vb[swfm_pkg::KIND_HIGH_FATAL] &&
                   v > thr_store[{s, swfm_pkg::KIND_HIGH_FATAL}]) ||
                  (vb[swfm_pkg::KIND_LOW_FATAL] &&
                   v < thr_store[{s, swfm_pkg::KIND_LOW_FATAL}]);
          warn  = (vb[swfm_pkg::KIND_HIGH_WARN] &&
                   v > thr_store[{s, swfm_pkg::KIND_HIGH_WARN}]) ||
                  (vb[swfm_pkg::KIND_LOW_WARN] &&
                   v < thr_store[{s, swfm_pkg::KIND_LOW_WARN}]);
          calm  = (vb[swfm_pkg::KIND_HIGH_WARN] &&
                   v <= thr_store[{s, swfm_pkg::KIND_HIGH_WARN}]) ||
                  (vb[swfm_pkg::KIND_LOW_WARN] &&
                   v >= thr_store[{s, swfm_pkg::KIND_LOW_WARN}]);
          trip = fatal || warn;
          prev = was_tripped[s];
          r.level = fatal ? swfm_pkg::LVL_FATAL :
                    (warn ? swfm_pkg::LVL_WARN : swfm_pkg::LVL_NORMAL);
          r.raise_event = trip;
          r.newly_tripped = trip && !prev;
          r.still_tripped = trip && prev;
          r.back_to_normal = calm && prev;
          seen_fatal = seen_fatal | fatal;
          seen_return = seen_return | (calm && prev);
          seen_trip = seen_trip | trip;
          was_tripped[s] = trip;
        end
        if (it.last_in_scan) begin
          r.scan_fatal = seen_fatal;
          r.all_clear = seen_return && !seen_trip;
          seen_fatal = 1'b0;
          seen_return = 1'b0;
          seen_trip = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic swfm_pkg::swfm_in_t random_item();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(swfm_pkg::swfm_in_t)-1:0];
  endfunction

  function automatic swfm_pkg::swfm_in_t sample_item(input logic [6:0] s,
                                                     input logic [31:0] v,
                                                     input logic ok, input logic last);
    swfm_pkg::swfm_in_t it;
    it = '0;
    it.operation = swfm_pkg::OP_SAMPLE;
    it.sensor_index = s;
    it.sample_value = v;
    it.read_ok = ok;
    it.last_in_scan = last;
    return it;
  endfunction

  function automatic swfm_pkg::swfm_in_t load_item(input logic [6:0] s,
                                                   input logic [1:0] kind,
                                                   input logic [31:0] v,
                                                   input logic present,
                                                   input logic temp);
    swfm_pkg::swfm_in_t it;
    it = '0;
    it.operation = swfm_pkg::OP_LOAD;
    it.sensor_index = s;
    it.threshold_kind = kind;
    it.sample_value = v;
    it.threshold_present = present;
    it.temp_sensor = temp;
    return it;
  endfunction

  function automatic swfm_pkg::swfm_in_t clear_item(input logic [6:0] s);
    swfm_pkg::swfm_in_t it;
    it = random_item();
    it.operation = swfm_pkg::OP_CLEAR;
    it.sensor_index = s;
    return it;
  endfunction

  function automatic string show_report(input swfm_pkg::swfm_out_t r);
    return $sformatf({"level=%0d event=%b new=%b still=%b back=%b ignored=%b",
                      " fatal=%b clear=%b thr=%h"},
                     r.level, r.raise_event, r.newly_tripped, r.still_tripped,
                     r.back_to_normal, r.now_ignored, r.scan_fatal, r.all_clear,
                     r.stored_threshold);
  endfunction

  function automatic string field_diffs(input swfm_pkg::swfm_out_t want,
                                        input swfm_pkg::swfm_out_t got);
    string d;
    d = "";
    if (got.level !== want.level) d = {d, " level"};
    if (got.raise_event !== want.raise_event) d = {d, " raise_event"};
    if (got.newly_tripped !== want.newly_tripped) d = {d, " newly_tripped"};
    if (got.still_tripped !== want.still_tripped) d = {d, " still_tripped"};
    if (got.back_to_normal !== want.back_to_normal) d = {d, " back_to_normal"};
    if (got.now_ignored !== want.now_ignored) d = {d, " now_ignored"};
    if (got.scan_fatal !== want.scan_fatal) d = {d, " scan_fatal"};
    if (got.all_clear !== want.all_clear) d = {d, " all_clear"};
    if (got.stored_threshold !== want.stored_threshold) d = {d, " stored_threshold"};
    return d;
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("ERROR: %s", msg);
  endtask

  // Offers one transaction and holds it until it is taken, then maybe pauses.
  task automatic send_item(input swfm_pkg::swfm_in_t item);
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_reports.push_back(monitor_step(item));
    n_items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) :
                                                 $urandom_range(1, 16);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers back to back; only called while the block is idle.
  task automatic write_settings(input logic [9:0] limit_val, input logic [9:0] margin_val,
                                input logic [9:0] pct_val);
    logic [1:0] regs [3];
    logic [9:0] vals [3];
    regs = '{swfm_pkg::CFG_ERROR_LIMIT, swfm_pkg::CFG_TEMP_MARGIN,
             swfm_pkg::CFG_POWER_PERCENT};
    vals = '{limit_val, margin_val, pct_val};
    for (int r = 0; r < 3; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[r];
      cfg_data <= vals[r];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      case (regs[r])
        swfm_pkg::CFG_ERROR_LIMIT: cur_error_limit = vals[r][4:0];
        swfm_pkg::CFG_TEMP_MARGIN: cur_temp_margin = vals[r];
        default:                   cur_power_pct = vals[r][5:0];
      endcase
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Mostly well-formed scans over small sensor groups, with some noise mixed in.
  task automatic run_sensor_traffic(input int n_new);
    int stop_at, group_size;
    logic [31:0] center, spread;
    logic [6:0] base, s;
    logic [1:0] kind;
    swfm_pkg::swfm_in_t it;
    stop_at = n_items_sent + n_new;
    while (n_items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 12) begin
        send_item(random_item());
      end else begin
        base = 7'($urandom);
        group_size = $urandom_range(1, 6);
        for (int i = 0; i < group_size; i++) begin
          s = base + 7'(i);
          if ($urandom_range(0, 19) == 0) send_item(clear_item(s));
          if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 3))
              0:       center = 32'($urandom_range(0, 3000));
              1:       center = 32'hFFFF_FFFF - 32'($urandom_range(0, 3000));
              default: center = $urandom;
            endcase
            spread = 32'($urandom_range(1, 4000));
            for (int k = 0; k < 4; k++) begin
              kind = 2'(k);
              it = random_item();
              it.operation = swfm_pkg::OP_LOAD;
              it.sensor_index = s;
              it.threshold_kind = kind;
              it.threshold_present = ($urandom_range(0, 9) != 0);
              case (kind)
                swfm_pkg::KIND_HIGH_FATAL: it.sample_value = center + 2 * spread;
                swfm_pkg::KIND_HIGH_WARN:  it.sample_value = center + spread;
                swfm_pkg::KIND_LOW_FATAL:  it.sample_value = center - 2 * spread;
                default:                   it.sample_value = center - spread;
              endcase
              send_item(it);
            end
          end
        end
        repeat ($urandom_range(1, 4)) begin
          for (int i = 0; i < group_size; i++) begin
            s = base + 7'(i);
            it = random_item();
            it.operation = swfm_pkg::OP_SAMPLE;
            it.sensor_index = s;
            it.read_ok = ($urandom_range(0, 99) >= read_fail_pct);
            // Now and then the end-of-scan mark is dropped or lands early.
            it.last_in_scan = (i == group_size - 1) ^ ($urandom_range(0, 24) == 0);
            kind = 2'($urandom);
            if (thr_valid[s][kind] && $urandom_range(0, 7) != 0)
              it.sample_value = thr_store[{s, kind}] + 32'($urandom_range(0, 4)) - 32'd2;
            send_item(it);
          end
        end
      end
    end
  endtask

  task automatic test_unconfigured_sensors();
    swfm_pkg::swfm_in_t it;
    send_item(sample_item(S_FIRST, 32'd0, 1'b1, 1'b1));
    it = '1;
    it.operation = swfm_pkg::OP_NONE;
    send_item(it);
  endtask

  task automatic test_threshold_loads();
    // Saturation at both ends of the range on the highest sensor index.
    send_item(load_item(S_LAST, swfm_pkg::KIND_HIGH_FATAL, 32'd0, 1'b1, 1'b1));
    send_item(load_item(S_LAST, swfm_pkg::KIND_HIGH_WARN, 32'hFFFF_FFFF, 1'b1, 1'b0));
    send_item(load_item(S_LAST, swfm_pkg::KIND_LOW_FATAL, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_item(load_item(S_LAST, swfm_pkg::KIND_LOW_WARN, 32'hFFFF_FFFF, 1'b1, 1'b0));
    send_item(load_item(S_DIR, swfm_pkg::KIND_HIGH_FATAL, 32'd2000, 1'b1, 1'b1));
    send_item(load_item(S_DIR, swfm_pkg::KIND_HIGH_WARN, 32'd1000, 1'b1, 1'b0));
    send_item(load_item(S_DIR, swfm_pkg::KIND_LOW_FATAL, 32'd10, 1'b1, 1'b1));
    send_item(load_item(S_DIR, swfm_pkg::KIND_LOW_FATAL, 32'd10, 1'b0, 1'b1));
    send_item(load_item(S_DIR, swfm_pkg::KIND_LOW_FATAL, 32'd10, 1'b1, 1'b1));
    send_item(load_item(S_DIR, swfm_pkg::KIND_LOW_WARN, 32'd100, 1'b1, 1'b0));
  endtask

  task automatic test_level_classification();
    send_item(sample_item(S_DIR, 32'd500, 1'b1, 1'b0));
    send_item(sample_item(S_DIR, 32'd1000, 1'b1, 1'b0));
    send_item(sample_item(S_DIR, 32'd3000, 1'b1, 1'b0));
    send_item(sample_item(S_DIR, 32'd10, 1'b1, 1'b0));
    send_item(sample_item(S_DIR, 32'd50, 1'b1, 1'b1));
    send_item(sample_item(S_DIR, 32'd500, 1'b1, 1'b1));
  endtask

  task automatic test_read_failures();
    drain_results();
    write_settings(10'd2, swfm_pkg::TEMP_MARGIN_RST, 10'(swfm_pkg::POWER_PERCENT_RST));
    send_item(sample_item(S_DIR, 32'd500, 1'b0, 1'b0));
    send_item(sample_item(S_DIR, 32'd500, 1'b0, 1'b0));
    send_item(sample_item(S_DIR, 32'd3000, 1'b1, 1'b1));
    send_item(clear_item(S_DIR));
    send_item(sample_item(S_DIR, 32'd5000, 1'b1, 1'b1));
  endtask

  task automatic test_minimum_settings();
    drain_results();
    write_settings(10'd1, 10'd0, 10'd0);
    read_fail_pct = 10;
    run_sensor_traffic(250);
  endtask

  task automatic test_maximum_settings();
    drain_results();
    write_settings(10'd31, 10'd1023, 10'd63);
    read_fail_pct = 35;
    run_sensor_traffic(250);
  endtask

  task automatic test_random_settings();
    drain_results();
    write_settings(10'($urandom), 10'($urandom), 10'($urandom));
    read_fail_pct = $urandom_range(3, 25);
    run_sensor_traffic(250);
  endtask

  // The receiver holds off while the sender keeps a long burst going.
  task automatic test_output_backpressure();
    drain_results();
    write_settings(10'(swfm_pkg::ERROR_LIMIT_RST), swfm_pkg::TEMP_MARGIN_RST,
                   10'(swfm_pkg::POWER_PERCENT_RST));
    read_fail_pct = 10;
    hold_requests++;
    burst_left = 80;
    run_sensor_traffic(260);
  endtask

  always @(posedge clk) begin : check_results
    swfm_pkg::swfm_out_t want;
    string bad;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      n_results++;
      if (pending_reports.size() == 0) begin
        note_failure($sformatf("result %0d with none expected: %s", n_results,
                               show_report(out_data)));
      end else begin
        want = pending_reports.pop_front();
        bad = field_diffs(want, out_data);
        if (bad != "")
          note_failure($sformatf("result %0d differs in%s\n  expected %s\n  actual   %s",
                                 n_results, bad, show_report(want), show_report(out_data)));
        if (want.level == swfm_pkg::LVL_FATAL) n_fatal++;
        if (want.level == swfm_pkg::LVL_WARN) n_warn++;
        if (want.level == swfm_pkg::LVL_SKIP) n_skip++;
        if (want.now_ignored) n_newly_ignored++;
      end
    end
  end

  // Receiver stall pattern, with an occasional long hold-off on request.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 20);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 70);
        default:     out_stall <= !out_stall;
      endcase
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no transaction for %0d cycles, %0d results outstanding.",
             WATCHDOG_LIMIT, pending_reports.size());
    $display("sensor_warn_fatal_monitor_tb failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_unconfigured_sensors();
    test_threshold_loads();
    test_level_classification();
    test_read_failures();
    test_minimum_settings();
    test_maximum_settings();
    test_random_settings();
    test_output_backpressure();
    drain_results();
    $display("Sent %0d transactions under %0d register settings, %0s %0d-cycle hold-off.",
             n_items_sent, n_settings, "with a", HOLD_CYCLES);
    $display("Checked %0d results: %0d fatal, %0d warning, %0d skipped, %0d ignores.",
             n_results, n_fatal, n_warn, n_skip, n_newly_ignored);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0)
      $display("sensor_warn_fatal_monitor_tb passed");
    else
      $display("sensor_warn_fatal_monitor_tb failed");
    $finish;
  end

endmodule

// ===== sensor_warn_fatal_monitor.f =====
src/swfm_pkg.sv
src/swfm_margin.sv
src/sensor_warn_fatal_monitor.sv
sim/sensor_warn_fatal_monitor_tb.sv
